// ===== hdl/http_request_header_parser_core_assert.svh =====
// Assertion macros for the HTTP request header parser core.
// Depends on nothing; included by modules that check their own logic.
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HRHP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hrhp assertion failed");
`define HRHP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hrhp assertion failed");
`else
`define HRHP_ASSERT(label, clk, rst_n, prop)
`define HRHP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/hrhp_pkg.sv =====
// Shared types, codes and character helpers for the HTTP request header parser.
// No dependencies; imported by hrhp_step and the top level.
package hrhp_pkg;

    localparam int ROUTE_BYTES = 128;
    localparam int OFFSET_BITS = 16;

    typedef enum logic [3:0] {
        PH_VERB       = 4'd0,
        PH_ROUTE      = 4'd1,
        PH_VERSION    = 4'd2,
        PH_VERSION_CR = 4'd3,
        PH_KEY        = 4'd4,
        PH_SEP        = 4'd5,
        PH_VALUE      = 4'd6,
        PH_VAL_CR1    = 4'd7,
        PH_VAL_LF1    = 4'd8,
        PH_VAL_CR2    = 4'd9,
        PH_BODY       = 4'd10,
        PH_HALT       = 4'd11
    } t_phase;

    localparam logic [2:0] ROLE_SKIP    = 3'd0;
    localparam logic [2:0] ROLE_VERB    = 3'd1;
    localparam logic [2:0] ROLE_ROUTE   = 3'd2;
    localparam logic [2:0] ROLE_VERSION = 3'd3;
    localparam logic [2:0] ROLE_KEY     = 3'd4;
    localparam logic [2:0] ROLE_VALUE   = 3'd5;
    localparam logic [2:0] ROLE_BODY    = 3'd6;

    localparam logic [1:0] VERB_NONE  = 2'd0;
    localparam logic [1:0] VERB_GET   = 2'd1;
    localparam logic [1:0] VERB_POST  = 2'd2;
    localparam logic [1:0] VERB_UNSUP = 2'd3;

    localparam logic [1:0] STAT_PARSING  = 2'd0;
    localparam logic [1:0] STAT_BODY     = 2'd1;
    localparam logic [1:0] STAT_ABORT    = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [7:0] ROUTE_MAX = 8'(ROUTE_BYTES);

    typedef struct packed {
        t_phase                 phase;
        logic                   in_token;
        logic [1:0]             vflags;
        logic [7:0]             tlen;
        logic [OFFSET_BITS-1:0] pos;
        logic [1:0]             verb;
        logic [1:0]             status;
    } t_state;

    typedef struct packed {
        logic [2:0]  role;
        logic        tend;
        logic [1:0]  verb;
        logic [1:0]  status;
        logic [15:0] offset;
        logic [7:0]  data;
        logic        last;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:    PH_VERB,
        in_token: 1'b0,
        vflags:   2'b11,
        tlen:     8'd0,
        pos:      '0,
        verb:     VERB_NONE,
        status:   STAT_PARSING
    };

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h53;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/hrhp_step.sv =====
// Per-byte parse decision: next parse state and the result for one request byte.
// Depends on hrhp_pkg.
module hrhp_step (
    input  hrhp_pkg::t_state  i_state,
    input  logic [7:0]        i_data,
    input  logic              i_first,
    input  logic              i_last,
    output hrhp_pkg::t_state  o_state,
    output hrhp_pkg::t_result o_result
);
    import hrhp_pkg::*;

    t_state                    s;
    t_state                    n;
    logic [2:0]                role;
    logic                      tend;
    logic                      blank;
    logic [OFFSET_BITS+15:0]   off_ext;

    always_comb begin
        s     = i_first ? STATE_RESET : i_state;
        n     = s;
        role  = ROLE_SKIP;
        tend  = 1'b0;
        blank = is_blank(i_data);

        case (s.phase)
            PH_VERB: begin
                if (!s.in_token) begin
                    if (!blank) begin
                        n.in_token = 1'b1;
                        n.vflags   = {i_data == post_char(2'd0), i_data == get_char(2'd0)};
                        n.tlen     = 8'd1;
                        role       = ROLE_VERB;
                    end
                end else if (!blank) begin
                    n.vflags[0] = s.vflags[0] && (s.tlen < 8'd3)
                                  && (i_data == get_char(s.tlen[1:0]));
                    n.vflags[1] = s.vflags[1] && (s.tlen < 8'd4)
                                  && (i_data == post_char(s.tlen[1:0]));
                    n.tlen      = (s.tlen == 8'hFF) ? s.tlen : s.tlen + 8'd1;
                    role        = ROLE_VERB;
                end else begin
                    role       = ROLE_VERB;
                    tend       = 1'b1;
                    n.in_token = 1'b0;
                    n.tlen     = 8'd0;
                    if (s.vflags[0] && s.tlen == 8'd3) begin
                        n.verb  = VERB_GET;
                        n.phase = PH_ROUTE;
                    end else if (s.vflags[1] && s.tlen == 8'd4) begin
                        n.verb  = VERB_POST;
                        n.phase = PH_ROUTE;
                    end else begin
                        n.verb   = VERB_UNSUP;
                        n.status = STAT_ABORT;
                        n.phase  = PH_HALT;
                    end
                end
            end
            PH_ROUTE: begin
                if (!s.in_token) begin
                    if (!blank) begin
                        n.in_token = 1'b1;
                        n.tlen     = 8'd1;
                        role       = ROLE_ROUTE;
                    end
                end else if (blank) begin
                    role       = ROLE_ROUTE;
                    tend       = 1'b1;
                    n.in_token = 1'b0;
                    n.tlen     = 8'd0;
                    n.phase    = PH_VERSION;
                end else if (s.tlen >= ROUTE_MAX) begin
                    n.status   = STAT_OVERFLOW;
                    n.in_token = 1'b0;
                    n.phase    = PH_HALT;
                end else begin
                    n.tlen = s.tlen + 8'd1;
                    role   = ROLE_ROUTE;
                end
            end
            PH_VERSION, PH_VERSION_CR: begin
                if (s.phase == PH_VERSION_CR && i_data == CH_LF) begin
                    n.phase    = PH_KEY;
                    n.in_token = 1'b0;
                end else if (i_data == CH_CR) begin
                    n.phase = PH_VERSION_CR;
                end else begin
                    n.phase = PH_VERSION;
                    role    = ROLE_VERSION;
                end
            end
            PH_KEY: begin
                if (!s.in_token) begin
                    if (!blank) begin
                        n.in_token = 1'b1;
                        role       = ROLE_KEY;
                    end
                end else if (i_data == CH_COLON) begin
                    role       = ROLE_KEY;
                    tend       = 1'b1;
                    n.in_token = 1'b0;
                    n.phase    = PH_VALUE;
                end else if (!blank) begin
                    role = ROLE_KEY;
                end else begin
                    role       = ROLE_KEY;
                    tend       = 1'b1;
                    n.in_token = 1'b0;
                    n.phase    = PH_SEP;
                end
            end
            PH_SEP: begin
                if (i_data == CH_COLON) begin
                    n.phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (!s.in_token) begin
                    if (!blank) begin
                        n.in_token = 1'b1;
                        role       = ROLE_VALUE;
                    end
                end else if (i_data != CH_CR) begin
                    role = ROLE_VALUE;
                end else begin
                    role       = ROLE_VALUE;
                    tend       = 1'b1;
                    n.in_token = 1'b0;
                    n.phase    = PH_VAL_CR1;
                end
            end
            PH_VAL_CR1, PH_VAL_LF1, PH_VAL_CR2: begin
                if ((s.phase == PH_VAL_CR1 && i_data == CH_LF)
                    || (s.phase == PH_VAL_LF1 && i_data == CH_CR)
                    || (s.phase == PH_VAL_CR2 && i_data == CH_LF)) begin
                    n.phase = t_phase'(s.phase + 4'd1);
                end else begin
                    n.phase = PH_KEY;
                    if (!blank) begin
                        n.in_token = 1'b1;
                        role       = ROLE_KEY;
                    end
                end
            end
            PH_BODY: begin
                if (!blank) begin
                    role     = ROLE_BODY;
                    n.status = STAT_BODY;
                    n.phase  = PH_HALT;
                end
            end
            default: begin
            end
        endcase

        n.pos = s.pos + 1'b1;
    end

    assign off_ext         = {16'd0, s.pos};
    assign o_result.role   = role;
    assign o_result.tend   = tend;
    assign o_result.verb   = n.verb;
    assign o_result.status = n.status;
    assign o_result.offset = off_ext[15:0];
    assign o_result.data   = i_data;
    assign o_result.last   = i_last;
    assign o_state         = i_last ? STATE_RESET : n;

endmodule

// ===== hdl/http_request_header_parser_core.sv =====
// HTTP request header parser core: one request byte in, one classified byte out.
// Each accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle when not stalled; parse state updates as each byte enters r_res.
// Reset: i_rst_n synchronous, active low; clears both stages and the parse state.
// Depends on hrhp_pkg, hrhp_step and http_request_header_parser_core_assert.svh.
`include "http_request_header_parser_core_assert.svh"
module http_request_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tuser,   // first_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // byte_role[2:0], token_end[3], verb_code[5:4], parse_status[7:6],
    // byte_offset[23:8], data_out[31:24]
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast    // out_last
);
    import hrhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_first;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_state     r_state;

    t_state     n_state;
    t_result    n_res;
    logic       w_adv;
    logic       w_take;

    hrhp_step u_step (
        .i_state  (r_state),
        .i_data   (r_in_data),
        .i_first  (r_in_first),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_data  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser;
            r_in_last  <= i_s_axis_tlast;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_res.data, r_res.offset, r_res.status, r_res.verb,
                              r_res.tend, r_res.role};
    assign o_m_axis_tlast  = r_res.last;

    `HRHP_ASSERT(a_halt_skips, i_clk, i_rst_n,
        (w_adv && r_state.phase == PH_HALT && !r_in_first) |=> (r_res.role == ROLE_SKIP))
    `HRHP_ASSERT(a_body_status, i_clk, i_rst_n,
        (r_out_valid && r_res.role == ROLE_BODY) |-> (r_res.status == STAT_BODY))
    `HRHP_ASSERT(a_tend_role, i_clk, i_rst_n,
        (r_out_valid && r_res.tend) |-> (r_res.role != ROLE_SKIP))
    `HRHP_ASSERT(a_last_clears, i_clk, i_rst_n,
        (w_adv && r_in_last) |=> (r_state.phase == PH_VERB && r_state.pos == '0))
    `HRHP_ASSERT(a_pos_advance, i_clk, i_rst_n,
        (w_adv && !r_in_first && !r_in_last)
        |=> (r_state.pos == OFFSET_BITS'($past(r_state.pos) + 1'b1)))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for http_request_header_parser_core: drives request bytes on the
// input stream, predicts each classified byte in a local parser model and checks it.
// Depends on hrhp_pkg and the core RTL only.
module tb_top;
    import hrhp_pkg::*;

    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_BYTES   = 1900;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int MSG_REQUEST    = 0;
    localparam int MSG_NOISE      = 1;
    localparam int MSG_FRAMED     = 2;

    localparam logic [23:0] GET_TEXT  = "GET";
    localparam logic [31:0] POST_TEXT = "POST";
    localparam logic [23:0] UNPINNED  = '0;

    typedef struct packed {
        logic [7:0]  b;
        logic        first;
        logic        last;
        logic        pinned;
        logic [2:0]  role;
        logic        tend;
        logic [1:0]  verb;
        logic [1:0]  status;
        logic [15:0] offset;
    } t_dir_row;

    typedef struct packed {
        logic    on;
        t_result cls;
    } t_pin;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_result     pending_classes[$];
    t_pin        pinned_q[$];
    logic [7:0]  msg_bytes[$];
    int          errors = 0;
    int          sent_count = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    t_phase      hp_phase;
    logic        hp_in_tok;
    logic [1:0]  hp_flags;
    logic [7:0]  hp_tlen;
    logic [15:0] hp_pos;
    logic [1:0]  hp_verb;
    logic [1:0]  hp_status;

    t_dir_row dir_rows [DIR_ROWS] = '{
        {"G",      1'b1, 1'b0, 1'b1, ROLE_VERB, 1'b0, VERB_NONE, STAT_PARSING, 16'd0},
        {"E",      1'b0, 1'b0, 1'b0, UNPINNED},
        {"T",      1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_SP,    1'b0, 1'b0, 1'b1, ROLE_VERB, 1'b1, VERB_GET, STAT_PARSING, 16'd3},
        {"/",      1'b0, 1'b0, 1'b0, UNPINNED},
        {8'hFF,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_SP,    1'b0, 1'b0, 1'b0, UNPINNED},
        {"H",      1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_CR,    1'b0, 1'b0, 1'b0, UNPINNED},
        {"X",      1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_CR,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_LF,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_COLON, 1'b0, 1'b0, 1'b0, UNPINNED},
        {"k",      1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_SP,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_COLON, 1'b0, 1'b0, 1'b0, UNPINNED},
        {8'h00,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_CR,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_LF,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_CR,    1'b0, 1'b0, 1'b0, UNPINNED},
        {CH_LF,    1'b0, 1'b0, 1'b0, UNPINNED},
        {"B",      1'b0, 1'b0, 1'b1, ROLE_BODY, 1'b0, VERB_GET, STAT_BODY, 16'd21},
        {8'h80,    1'b0, 1'b1, 1'b1, ROLE_SKIP, 1'b0, VERB_GET, STAT_BODY, 16'd22},
        {"Q",      1'b1, 1'b0, 1'b0, UNPINNED},
        {CH_SP,    1'b0, 1'b1, 1'b1, ROLE_VERB, 1'b1, VERB_UNSUP, STAT_ABORT, 16'd1}
    };

    http_request_header_parser_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SP || b == CH_CR || b == CH_LF;
    endfunction

    function automatic void restart_parser();
        hp_phase  = PH_VERB;
        hp_in_tok = 1'b0;
        hp_flags  = 2'b11;
        hp_tlen   = 8'd0;
        hp_pos    = 16'd0;
        hp_verb   = VERB_NONE;
        hp_status = STAT_PARSING;
    endfunction

    function automatic logic [2:0] open_key(input logic [7:0] b);
        hp_phase = PH_KEY;
        if (is_ws(b)) begin
            return ROLE_SKIP;
        end
        hp_in_tok = 1'b1;
        return ROLE_KEY;
    endfunction

    function automatic t_result classify_byte(input logic [7:0] b, input logic first,
                                              input logic last);
        t_result r;
        int      k;
        r = '0;
        if (first) begin
            restart_parser();
        end
        r.offset = hp_pos;
        case (hp_phase) inside
            PH_VERB: begin
                if (!hp_in_tok) begin
                    if (!is_ws(b)) begin
                        hp_in_tok = 1'b1;
                        hp_flags  = 2'b11;
                        hp_tlen   = 8'd0;
                        r.role    = ROLE_VERB;
                    end
                end else if (!is_ws(b)) begin
                    k = hp_tlen;
                    if (k >= 3 || b != GET_TEXT[8*(2-k) +: 8]) hp_flags[0] = 1'b0;
                    if (k >= 4 || b != POST_TEXT[8*(3-k) +: 8]) hp_flags[1] = 1'b0;
                    if (hp_tlen != 8'hFF) hp_tlen++;
                    r.role = ROLE_VERB;
                end
                if (hp_in_tok && is_ws(b)) begin
                    r.role    = ROLE_VERB;
                    r.tend    = 1'b1;
                    hp_in_tok = 1'b0;
                    if (hp_flags[0] && hp_tlen == 8'd3) begin
                        hp_verb  = VERB_GET;
                        hp_phase = PH_ROUTE;
                    end else if (hp_flags[1] && hp_tlen == 8'd4) begin
                        hp_verb  = VERB_POST;
                        hp_phase = PH_ROUTE;
                    end else begin
                        hp_verb   = VERB_UNSUP;
                        hp_status = STAT_ABORT;
                        hp_phase  = PH_HALT;
                    end
                    hp_tlen = 8'd0;
                end else if (r.role == ROLE_VERB && hp_tlen == 8'd0) begin
                    if (b != GET_TEXT[23:16]) hp_flags[0] = 1'b0;
                    if (b != POST_TEXT[31:24]) hp_flags[1] = 1'b0;
                    hp_tlen = 8'd1;
                end
            end
            PH_ROUTE: begin
                if (!hp_in_tok) begin
                    if (!is_ws(b)) begin
                        hp_in_tok = 1'b1;
                        hp_tlen   = 8'd1;
                        r.role    = ROLE_ROUTE;
                    end
                end else if (is_ws(b)) begin
                    r.role    = ROLE_ROUTE;
                    r.tend    = 1'b1;
                    hp_in_tok = 1'b0;
                    hp_tlen   = 8'd0;
                    hp_phase  = PH_VERSION;
                end else if (hp_tlen >= ROUTE_BYTES) begin
                    hp_status = STAT_OVERFLOW;
                    hp_in_tok = 1'b0;
                    hp_phase  = PH_HALT;
                end else begin
                    hp_tlen++;
                    r.role = ROLE_ROUTE;
                end
            end
            PH_VERSION, PH_VERSION_CR: begin
                if (hp_phase == PH_VERSION_CR && b == CH_LF) begin
                    hp_phase  = PH_KEY;
                    hp_in_tok = 1'b0;
                end else if (b == CH_CR) begin
                    hp_phase = PH_VERSION_CR;
                end else begin
                    hp_phase = PH_VERSION;
                    r.role   = ROLE_VERSION;
                end
            end
            PH_KEY: begin
                if (!hp_in_tok) begin
                    r.role = open_key(b);
                end else if (b == CH_COLON) begin
                    r.role    = ROLE_KEY;
                    r.tend    = 1'b1;
                    hp_in_tok = 1'b0;
                    hp_phase  = PH_VALUE;
                end else if (!is_ws(b)) begin
                    r.role = ROLE_KEY;
                end else begin
                    r.role    = ROLE_KEY;
                    r.tend    = 1'b1;
                    hp_in_tok = 1'b0;
                    hp_phase  = PH_SEP;
                end
            end
            PH_SEP: begin
                if (b == CH_COLON) hp_phase = PH_VALUE;
            end
            PH_VALUE: begin
                if (!hp_in_tok) begin
                    if (!is_ws(b)) begin
                        hp_in_tok = 1'b1;
                        r.role    = ROLE_VALUE;
                    end
                end else if (b != CH_CR) begin
                    r.role = ROLE_VALUE;
                end else begin
                    r.role    = ROLE_VALUE;
                    r.tend    = 1'b1;
                    hp_in_tok = 1'b0;
                    hp_phase  = PH_VAL_CR1;
                end
            end
            PH_VAL_CR1: begin
                if (b == CH_LF) hp_phase = PH_VAL_LF1;
                else r.role = open_key(b);
            end
            PH_VAL_LF1: begin
                if (b == CH_CR) hp_phase = PH_VAL_CR2;
                else r.role = open_key(b);
            end
            PH_VAL_CR2: begin
                if (b == CH_LF) hp_phase = PH_BODY;
                else r.role = open_key(b);
            end
            PH_BODY: begin
                if (!is_ws(b)) begin
                    r.role    = ROLE_BODY;
                    hp_status = STAT_BODY;
                    hp_phase  = PH_HALT;
                end
            end
            default: begin
            end
        endcase
        hp_pos++;
        r.verb   = hp_verb;
        r.status = hp_status;
        r.data   = b;
        r.last   = last;
        if (last) begin
            restart_parser();
        end
        return r;
    endfunction

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_pin    pin;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[2:0], o_m_axis_tdata[3], o_m_axis_tdata[5:4],
                       o_m_axis_tdata[7:6], o_m_axis_tdata[23:8], o_m_axis_tdata[31:24],
                       o_m_axis_tlast};
                if (pending_classes.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: %h", $time, got);
                end else begin
                    want = pending_classes.pop_front();
                    check_field("byte_role", want.role, got.role);
                    check_field("token_end", want.tend, got.tend);
                    check_field("verb_code", want.verb, got.verb);
                    check_field("parse_status", want.status, got.status);
                    check_field("byte_offset", want.offset, got.offset);
                    check_field("data_out", want.data, got.data);
                    check_field("out_last", want.last, got.last);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = classify_byte(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
                pin  = pinned_q.pop_front();
                if (pin.on) want = pin.cls;
                pending_classes = {pending_classes, want};
            end
        end
    end

    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                stall = idle_on ? idle_len() : 0;
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic first, input logic last,
                              input t_pin pin);
        int gap;
        gap = idle_on ? idle_len() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pinned_q = {pinned_q, pin};
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // drop valid and hold until every classified byte has come back or DRAIN_LIMIT runs out
    task automatic pause_sender();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        for (int w = 0; w < DRAIN_LIMIT && pending_classes.size() != 0; w++) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0) return 8'($urandom);
        c = 8'($urandom_range(33, 126));
        if (c == CH_COLON) c = "_";
        return c;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 2))
            0: return CH_SP;
            1: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        msg_bytes = {msg_bytes, b};
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_text(input int n);
        repeat (n) add_byte(text_char());
    endfunction

    function automatic void line_end();
        if ($urandom_range(0, 9) == 0) begin
            add_byte(CH_CR);
            add_byte(text_char());
        end else begin
            add_str("\r\n");
        end
    endfunction

    function automatic void build_request();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) add_byte(ws_char());
        end
        n = $urandom_range(0, 19);
        if (n < 2) add_text($urandom_range(1, 5));
        else if (n < 11) add_str("GET");
        else add_str("POST");
        add_str(" ");
        if ($urandom_range(0, 4) == 0) add_str(" ");
        add_str("/");
        if ($urandom_range(0, 9) == 0) n = $urandom_range(ROUTE_BYTES - 3, ROUTE_BYTES + 2);
        else n = $urandom_range(0, 20);
        add_text(n);
        if ($urandom_range(0, 9) == 0) begin
            add_str(" ");
            add_text($urandom_range(1, 8));
        end else begin
            add_str(" HTTP/1.1");
        end
        line_end();
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 9) == 0) add_byte(CH_COLON);
            add_text($urandom_range(1, 10));
            if ($urandom_range(0, 3) == 0) add_str(" ");
            add_byte(CH_COLON);
            if ($urandom_range(0, 1) == 0) add_str(" ");
            add_text($urandom_range(1, 16));
            line_end();
        end
        line_end();
        if ($urandom_range(0, 4) == 0) add_byte(ws_char());
        add_text($urandom_range(0, 8));
    endfunction

    function automatic void corrupt_message();
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
            end
        end
    endfunction

    task automatic send_message(input int mode);
        logic lead;
        logic tail;
        int   top;
        lead = (mode == MSG_FRAMED) || ($urandom_range(0, 99) < 85);
        tail = (mode == MSG_FRAMED) || ($urandom_range(0, 99) < 85);
        top  = msg_bytes.size() - 1;
        for (int i = 0; i <= top; i++) begin
            if (mode == MSG_NOISE) begin
                offer_byte(msg_bytes[i], $urandom_range(0, 9) == 0,
                           $urandom_range(0, 9) == 0, '0);
            end else begin
                offer_byte(msg_bytes[i], lead && i == 0, tail && i == top, '0);
            end
        end
        msg_bytes.delete();
    endtask

    initial begin
        t_pin pin;
        int   kind;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        restart_parser();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            pin.on  = dir_rows[i].pinned;
            pin.cls = {dir_rows[i].role, dir_rows[i].tend, dir_rows[i].verb,
                       dir_rows[i].status, dir_rows[i].offset, dir_rows[i].b,
                       dir_rows[i].last};
            offer_byte(dir_rows[i].b, dir_rows[i].first, dir_rows[i].last, pin);
        end

        for (int m = 0; sent_count < DIR_ROWS + RANDOM_BYTES; m++) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if (m == 4 || $urandom_range(0, 39) == 0) pause_sender();
            if (m == 2 || $urandom_range(0, 29) == 0) begin
                rx_hold_req = 1'b1;
                idle_on     = 1'b0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                build_request();
                if (kind >= 65) corrupt_message();
                send_message(MSG_REQUEST);
            end else begin
                repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
                send_message(MSG_NOISE);
            end
        end

        // close with one framed request that carries a short body
        idle_on = 1'b0;
        add_str("POST /w HTTP/1.1\r\n\r\n");
        add_text(8);
        send_message(MSG_FRAMED);

        idle_on = 1'b1;
        pause_sender();
        repeat (8) @(posedge i_clk);
        if (pending_classes.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_classes.size());
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
